### rtl/heard_station_table_core_assert.svh
// Assertion macros used by the checker file of the heard station table.
// No dependencies; take in with a plain include.
`ifndef HEARD_STATION_TABLE_CORE_ASSERT_SVH
`define HEARD_STATION_TABLE_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset
`define HST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included
`define HST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/hst_pkg.sv
// Shared types and constants of the heard station table.
// No dependencies; imported by the core and its checker.
package hst_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int CALL_HIGH_W = 48;
    localparam int CALL_LOW_W  = 32;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int SLOT_W      = 4;

    // stream widths: fields packed from bit 0, padded to whole bytes
    localparam int S_TDATA_W = CALL_HIGH_W + CALL_LOW_W + STAMP_W;
    localparam int M_FIELD_W = SLOT_W + COUNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // one stored station
    typedef struct packed {
        logic [CALL_HIGH_W-1:0] call_high;
        logic [CALL_LOW_W-1:0]  call_low;
        logic [STAMP_W-1:0]     last_seen;
        logic [COUNT_W-1:0]     count;
        logic                   source;
    } entry_t;

endpackage

### rtl/heard_station_table_core.sv
// Heard station table: entry memory, scan sequencer and result register.
// Depends on hst_pkg.

// A table of TABLE_ENTRIES recently heard stations held in one synchronous
// memory. Each input transfer carries a callsign, a time and a source flag;
// the block reads every entry in turn through the memory's single read port,
// looks for an exact callsign match and tracks the entry with the smallest
// last-seen time, then writes back the updated or replaced entry and returns
// one result (slot, hit flag, saturating packet count). The block takes no new
// input transfer until it has passed its scan, drain and write states; the scan
// reads one entry per cycle through the read port, and the write state waits
// until the output register is free. The result waits in an output register,
// so a new item is taken while it is still unread. Reset clears the table at
// once through per-entry valid bits; no clearing pass is needed.
module heard_station_table_core
    import hst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // call_high [47:0], call_low [79:48], stamp [111:80]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // from_radio [0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot [3:0], heard_count [19:4], zero [23:20]
    output logic [M_TDATA_W-1:0] m_tdata,
    // hit [0]
    output logic                 m_tuser
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    state_t state_reg;

    // held input item
    logic [CALL_HIGH_W-1:0] call_high_reg;
    logic [CALL_LOW_W-1:0]  call_low_reg;
    logic [STAMP_W-1:0]     stamp_reg;
    logic                   radio_reg;

    // scan pipeline
    logic [AW-1:0] scan_addr_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_en_reg;
    entry_t        rd_data_reg;
    logic          rd_valid_reg;

    // scan results
    logic               found_reg;
    logic [AW-1:0]      match_idx_reg;
    logic [COUNT_W-1:0] match_cnt_reg;
    logic [AW-1:0]      old_idx_reg;
    logic [STAMP_W-1:0] least_reg;

    // storage
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // output register
    logic               m_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               s_xfer;
    logic               out_free;
    logic               do_write;
    logic [COUNT_W-1:0] rd_count;
    logic [STAMP_W-1:0] rd_last;
    logic               rd_hit;
    logic [AW-1:0]      wr_idx;
    logic [COUNT_W-1:0] new_count;
    entry_t             wr_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign do_write = (state_reg == ST_WRITE) && out_free;

    // an entry never written reads as all zero
    assign rd_count = rd_valid_reg ? rd_data_reg.count : '0;
    assign rd_last  = rd_valid_reg ? rd_data_reg.last_seen : '0;
    assign rd_hit   = rd_valid_reg && (rd_data_reg.call_high == call_high_reg)
                      && (rd_data_reg.call_low == call_low_reg);

    // build the entry to write back
    always_comb begin
        wr_idx = found_reg ? match_idx_reg : old_idx_reg;
        if (!found_reg) begin
            new_count = COUNT_ONE;
        end else if (match_cnt_reg == COUNT_MAX) begin
            new_count = COUNT_MAX;
        end else begin
            new_count = match_cnt_reg + COUNT_ONE;
        end
        wr_entry.call_high = call_high_reg;
        wr_entry.call_low  = call_low_reg;
        wr_entry.last_seen = stamp_reg;
        wr_entry.count     = new_count;
        wr_entry.source    = radio_reg;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_idx] <= wr_entry;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    // valid bits: cleared by reset, set on first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (do_write) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // sequencer, scan bookkeeping and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cmp_en_reg   <= (state_reg == ST_SCAN);
            cmp_idx_reg  <= scan_addr_reg;
            rd_valid_reg <= valid_reg[scan_addr_reg];

            if (m_valid_reg && m_tready && !do_write) begin
                m_valid_reg <= 1'b0;
            end

            // fold one entry into the match and oldest trackers
            if (cmp_en_reg) begin
                if (rd_hit && !found_reg) begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= cmp_idx_reg;
                    match_cnt_reg <= rd_count;
                end
                if ((cmp_idx_reg == '0) || (rd_last < least_reg)) begin
                    least_reg   <= rd_last;
                    old_idx_reg <= cmp_idx_reg;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    scan_addr_reg <= '0;
                    if (s_xfer) begin
                        call_high_reg <= s_tdata[CALL_HIGH_W-1:0];
                        call_low_reg  <= s_tdata[CALL_HIGH_W +: CALL_LOW_W];
                        stamp_reg     <= s_tdata[CALL_HIGH_W + CALL_LOW_W +: STAMP_W];
                        radio_reg     <= s_tuser;
                        found_reg     <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // issue one read a cycle
                    if (scan_addr_reg == LAST_IDX) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        scan_addr_reg <= scan_addr_reg + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        slot_reg    <= SLOT_W'(wr_idx);
                        hit_reg     <= found_reg;
                        count_reg   <= new_count;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELD_W)'(0), count_reg, slot_reg};

endmodule

### rtl/hst_checker.sv
// Port-level checker for the heard station table, with its bind.
// Depends on hst_pkg and heard_station_table_core_assert.svh.
`include "heard_station_table_core_assert.svh"

module hst_checker
    import hst_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // a pending result holds until taken
    `HST_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed before transfer")

    // reset drops any pending result
    `HST_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a replacement always starts its count at one
    `HST_ASSERT(a_miss_count, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[SLOT_W +: COUNT_W] == COUNT_ONE, "replaced entry count not one")

    // a hit always follows an earlier packet
    `HST_ASSERT(a_hit_count, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[SLOT_W +: COUNT_W] != '0 && m_tdata[SLOT_W +: COUNT_W] != COUNT_ONE, "hit count below two")

    // the block is busy for the cycle after taking an item
    `HST_ASSERT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken twice in a row")

endmodule

bind heard_station_table_core hst_checker u_hst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_heard_station_table_core.sv
// Testbench for heard_station_table_core: directed and random traffic
// checked against a behavioural model of the station table held in a scoreboard class.
// Depends on hst_pkg and the core RTL.
module tb_heard_station_table_core
    import hst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1325;
    localparam int QUIET_FROM   = 1000;     // no idling from this random item on
    localparam int HOLD_AT      = 300;      // random item at which the long stall starts
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int POOL_SIZE    = 24;
    localparam int MAX_REPORTS  = 30;

    // one expected result
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic [COUNT_W-1:0] heard_count;
    } station_reply_t;

    // Scoreboard: a mirror of the station table and the replies still owed
    class heard_table_model;
        bit [CALL_HIGH_W-1:0] call_hi   [TABLE_ENTRIES_DEF];
        bit [CALL_LOW_W-1:0]  call_lo   [TABLE_ENTRIES_DEF];
        bit [STAMP_W-1:0]     last_seen [TABLE_ENTRIES_DEF];
        bit [COUNT_W-1:0]     heard     [TABLE_ENTRIES_DEF];
        bit                   radio_src [TABLE_ENTRIES_DEF];
        station_reply_t       pending_replies[$];
        int errors    = 0;
        int hits      = 0;
        int evictions = 0;
        int saturated = 0;
        int checked   = 0;

        // update the mirror for one accepted packet and queue its reply
        function void record_heard(bit [CALL_HIGH_W-1:0] ch, bit [CALL_LOW_W-1:0] cl,
                                   bit [STAMP_W-1:0] stamp, bit radio);
            int idx;
            station_reply_t r;
            idx = -1;
            // exact match on a written entry, lowest index first
            for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
                if (idx < 0 && heard[k] != 0 && call_hi[k] == ch && call_lo[k] == cl)
                    idx = k;
            end
            r.hit = (idx >= 0);
            if (r.hit) begin
                hits++;
                if (heard[idx] != COUNT_MAX)
                    heard[idx] = heard[idx] + 1'b1;
                else
                    saturated++;
            end else begin
                // replace the strictly oldest entry, lowest index on a tie
                evictions++;
                idx = 0;
                for (int k = 1; k < TABLE_ENTRIES_DEF; k++) begin
                    if (last_seen[k] < last_seen[idx])
                        idx = k;
                end
                call_hi[idx] = ch;
                call_lo[idx] = cl;
                heard[idx]   = COUNT_ONE;
            end
            last_seen[idx] = stamp;
            radio_src[idx] = radio;
            r.slot        = idx[SLOT_W-1:0];
            r.heard_count = heard[idx];
            pending_replies.push_back(r);
        endfunction

        function void note_mismatch(string field, int want, int got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        // compare one result transfer with the oldest reply owed
        function void check_reply(bit [SLOT_W-1:0] slot, bit hit, bit [COUNT_W-1:0] cnt);
            station_reply_t want;
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %0d/%0b/%0d",
                             $time, slot, hit, cnt);
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            if (slot != want.slot)
                note_mismatch("slot", int'(want.slot), int'(slot));
            if (hit != want.hit)
                note_mismatch("hit", int'(want.hit), int'(hit));
            if (cnt != want.heard_count)
                note_mismatch("heard_count", int'(want.heard_count), int'(cnt));
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // call_high [47:0], call_low [79:48], stamp [111:80]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // from_radio [0]
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // slot [3:0], heard_count [19:4], zero [23:20]
    logic [M_TDATA_W-1:0] m_tdata;
    // hit [0]
    logic                 m_tuser;

    heard_table_model model = new();
    bit quiet_tail      = 1'b0;
    bit long_hold_armed = 1'b0;
    bit long_hold_taken = 1'b0;
    int cycle_count     = 0;
    int items_sent      = 0;

    heard_station_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, model.pending_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next ready value
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                model.check_reply(m_tdata[SLOT_W-1:0], m_tuser,
                                  m_tdata[SLOT_W +: COUNT_W]);
            if (long_hold_armed && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one packet and hold it until the block takes it; valid stays high
    task automatic offer_packet(bit [CALL_HIGH_W-1:0] ch, bit [CALL_LOW_W-1:0] cl,
                                bit [STAMP_W-1:0] stamp, bit radio);
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, cl, ch};
        s_tuser  <= radio;
        do
            @(posedge aclk);
        while (!s_tready);
        model.record_heard(ch, cl, stamp, radio);
        items_sent++;
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // Random ASCII callsign of 1 to 10 characters, first char in the top byte
    task automatic make_callsign(output bit [CALL_HIGH_W-1:0] ch,
                                 output bit [CALL_LOW_W-1:0] cl);
        string alphabet;
        int    len;
        byte   c;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
        len = $urandom_range(1, 10);
        ch = '0;
        cl = '0;
        for (int i = 0; i < len; i++) begin
            c = alphabet[$urandom_range(0, alphabet.len() - 1)];
            if (i < 6)
                ch[CALL_HIGH_W-1-8*i -: 8] = c;
            else
                cl[CALL_LOW_W-1-8*(i-6) -: 8] = c;
        end
    endtask

    initial begin
        bit [CALL_HIGH_W-1:0] pool_hi [POOL_SIZE];
        bit [CALL_LOW_W-1:0]  pool_lo [POOL_SIZE];
        bit [CALL_HIGH_W-1:0] ch;
        bit [CALL_LOW_W-1:0]  cl;
        bit [STAMP_W-1:0]     stamp;
        bit [STAMP_W-1:0]     clock_now;
        int pick;

        // Hold reset low, then release it
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: an all-zero callsign misses a cleared table, then hits itself
        offer_packet('0, '0, '0, 1'b0);
        offer_packet('0, '0, 32'd5, 1'b1);
        // all-ones callsign and time take the lowest of the empty slots
        offer_packet('1, '1, '1, 1'b1);
        offer_packet('1, '1, '1, 1'b0);
        // same high half, different low half must not match
        offer_packet('1, 32'h4142_4344, 32'd7, 1'b1);
        // fill the rest, two of them at an equal time
        for (int i = 0; i < 13; i++) begin
            make_callsign(ch, cl);
            offer_packet(ch, cl, (i < 2) ? 32'd20 : 32'd30 + i, i[0]);
        end
        // new callsigns evict the oldest: the zero callsign first, then the
        // differing low half, then the pair at an equal time
        for (int i = 0; i < 4; i++) begin
            make_callsign(ch, cl);
            offer_packet(ch, {cl[31:8], 8'h00} | 32'h1, 32'd100 + i, 1'b1);
        end
        // a hit on an entry with maximum time
        offer_packet('1, '1, 32'd200, 1'b1);

        // Random: mostly a pool of known stations so hits and evictions both occur
        for (int i = 0; i < POOL_SIZE; i++)
            make_callsign(pool_hi[i], pool_lo[i]);
        clock_now = 32'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == QUIET_FROM)
                quiet_tail = 1'b1;
            if (n == HOLD_AT)
                long_hold_armed = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                ch = pool_hi[pick];
                cl = pool_lo[pick];
            end else if (pick < 85) begin
                ch = CALL_HIGH_W'({$urandom(), $urandom()});
                cl = $urandom();
            end else if (pick < 95) begin
                // a fresh station joins the pool
                pick = $urandom_range(0, POOL_SIZE - 1);
                make_callsign(pool_hi[pick], pool_lo[pick]);
                ch = pool_hi[pick];
                cl = pool_lo[pick];
            end else begin
                ch = '0;
                cl = '0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                clock_now = clock_now + $urandom_range(0, 3);
                stamp = clock_now;
            end else if (pick < 90) begin
                stamp = $urandom();
            end else if (pick < 95) begin
                stamp = '0;
            end else begin
                stamp = '1;
            end
            offer_packet(ch, cl, stamp, 1'($urandom_range(0, 1)));
            sender_gap();
        end
        s_tvalid <= 1'b0;

        // Wait for every reply, then let the pipeline settle
        while (model.pending_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d packets: %0d hits (%0d at the count ceiling), %0d evictions.",
                 items_sent, model.hits, model.saturated, model.evictions);
        $display("Checked %0d replies with random gaps, one long output stall, %0d errors.",
                 model.checked, model.errors);
        if (model.errors == 0 && model.pending_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/hst_pkg.sv
rtl/heard_station_table_core.sv
rtl/hst_checker.sv
tb/tb_heard_station_table_core.sv
